[src/apu_frame_sequencer_and_mixer_assert.svh]
// Assertion macros shared by the sound control block.
// Included by the frame sequencer and the top level; no other dependencies.
`ifndef APU_FRAME_SEQUENCER_AND_MIXER_ASSERT_SVH
`define APU_FRAME_SEQUENCER_AND_MIXER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property on the rising clock edge, ignored while reset is high.
`define AFSM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sound control assertion failed");
// Check a property on every rising clock edge, reset included.
`define AFSM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("sound control assertion failed");
`else
`define AFSM_ASSERT(label, clk, rst, prop)
`define AFSM_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[src/afsm_pkg.sv]
// Types and codes for the sound control block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package afsm_pkg;

   // Item actions
   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_SAMPLE = 2'd1,
      ACT_READ   = 2'd2,
      ACT_WRITE  = 2'd3
   } action_type;

   // Bus register addresses
   typedef enum logic [1:0] {
      BUS_VOLUME  = 2'd0,
      BUS_ROUTING = 2'd1,
      BUS_MASTER  = 2'd2,
      BUS_UNUSED  = 2'd3
   } bus_addr_type;

   // Configuration register index (bit 2 of paddr selects the index)
   localparam logic CSR_GLOBAL_SHIFT = 1'b0;

   // Largest right shift applied to the mixed sum
   localparam logic [1:0] MIX_MAX_SHIFT = 2'd3;

   // Sequencer step with the envelope strobe
   localparam logic [2:0] STEP_ENVELOPE = 3'd7;

   // Channel levels, index 0 square one to index 3 noise
   typedef logic [3:0][3:0] level_array_type;

   // Frame sequencer strobes for the current tick
   typedef struct packed {
      logic length;
      logic sweep;
      logic envelope;
   } strobe_type;

endpackage

[src/afsm_frame_seq.sv]
// Frame sequencer: prescaler and eight-step sequence with its strobes.
// Depends on afsm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "apu_frame_sequencer_and_mixer_assert.svh"

module afsm_frame_seq
   import afsm_pkg::*;
#(
   parameter int PRESCALE_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   output strobe_type strobe
);

   logic [PRESCALE_BITS-1:0] prescaler_ff, prescaler_in;
   logic [2:0]               step_ff, step_in;
   logic                     fire;

   // Decode strobes for the current step when the prescaler reads zero
   always_comb begin
      fire            = (prescaler_ff == '0);
      strobe.length   = fire && !step_ff[0];
      strobe.sweep    = fire && (step_ff[1:0] == 2'b10);
      strobe.envelope = fire && (step_ff == STEP_ENVELOPE);
   end

   // Advance prescaler on every tick, step only when the prescaler wraps through zero
   always_comb begin
      prescaler_in = prescaler_ff;
      step_in      = step_ff;
      if (advance) begin
         prescaler_in = prescaler_ff + PRESCALE_BITS'(1);
         if (fire) begin
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescaler_ff <= '0;
         step_ff      <= '0;
      end else begin
         prescaler_ff <= prescaler_in;
         step_ff      <= step_in;
      end
   end

   `AFSM_ASSERT(a_sweep_with_length, clock, reset, strobe.sweep |-> strobe.length)
   `AFSM_ASSERT(a_length_not_envelope, clock, reset, strobe.length |-> !strobe.envelope)
   `AFSM_ASSERT(a_step_advance, clock, reset, (advance && fire) |=> (step_ff == $past(step_ff) + 3'd1))

endmodule

[src/afsm_mixer.sv]
// Mixer for one side: routed level sum, volume scale and global shift.
// Depends on afsm_pkg.
`timescale 1ns / 1ps

module afsm_mixer
   import afsm_pkg::*;
(
   input  level_array_type levels,
   input  logic [3:0]      routing,
   input  logic [2:0]      volume,
   input  logic            master_on,
   input  logic [1:0]      global_shift,
   output logic [9:0]      sample
);

   logic [5:0] sum;
   logic [3:0] gain;
   logic [8:0] scaled;
   logic [9:0] doubled;
   logic [1:0] shift_amt;

   // Sum routed levels, scale by 1 + volume, double, then shift down; zero while master is off
   always_comb begin
      sum = 6'd0;
      for (int k = 0; k < 4; k++) begin
         if (routing[k]) begin
            sum = sum + {2'b00, levels[k]};
         end
      end
      gain      = {1'b0, volume} + 4'd1;
      scaled    = 9'({3'b000, sum} * {5'b00000, gain});
      doubled   = {scaled, 1'b0};
      shift_amt = MIX_MAX_SHIFT - global_shift;
      sample    = master_on ? (doubled >> shift_amt) : 10'd0;
   end

endmodule

[src/apu_frame_sequencer_and_mixer.sv]
// Top level of the sound control block: input and result registers, bus registers, CSR port.
// Depends on afsm_pkg, afsm_frame_seq, afsm_mixer and the assertion macro header.
//
//   channel   ports            handshake           accepted when
//   input     req_*            req_valid/req_stall  req_valid && !req_stall
//   result    rsp_*            rsp_valid/rsp_stall  rsp_valid && !rsp_stall
//   config    psel..prdata     APB, pready = 1      psel && penable && pwrite
//
// One item per cycle sustained while rsp_stall is low; an accepted item passes through the input
// register and then the result register, which drives rsp_*.
// The result register frees the input register whenever it is empty or being taken.
// Reset is synchronous, active high; it clears valids, bus registers and the sequencer.
// A stalled result holds the input register, which then stalls req_*.
`timescale 1ns / 1ps
`include "apu_frame_sequencer_and_mixer_assert.svh"

module apu_frame_sequencer_and_mixer
   import afsm_pkg::*;
#(
   parameter int PRESCALE_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [1:0]  req_bus_address,
   input  logic [7:0]  req_write_data,
   input  logic [3:0]  req_square_one_level,
   input  logic [3:0]  req_square_two_level,
   input  logic [3:0]  req_wave_level,
   input  logic [3:0]  req_noise_level,
   input  logic [3:0]  req_channel_active,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_length_strobe,
   output logic        rsp_sweep_strobe,
   output logic        rsp_envelope_strobe,
   output logic [3:0]  rsp_run_strobes,
   output logic [9:0]  rsp_left_sample,
   output logic [9:0]  rsp_right_sample,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // Input register
   logic            in_valid_ff, in_valid_in;
   logic [1:0]      act_ff;
   logic [1:0]      addr_ff;
   logic [7:0]      wdata_ff;
   level_array_type levels_ff;
   logic [3:0]      active_ff;

   // Result register
   logic       out_valid_ff, out_valid_in;
   logic [7:0] read_data_ff, read_data_in;
   strobe_type strobe_ff, strobe_in;
   logic [3:0] run_ff, run_in;
   logic [9:0] left_ff, right_ff;

   // Bus and configuration registers
   logic [2:0] left_vol_ff, right_vol_ff;
   logic [3:0] left_route_ff, right_route_ff;
   logic       master_ff;
   logic [1:0] gshift_ff;

   logic       accept, take, out_free;
   action_type action;
   bus_addr_type bus_addr;
   strobe_type seq_strobe;
   logic [9:0] left_mix, right_mix;

   // Handshake: the input register moves on when the result register can take it
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign take      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign action    = action_type'(act_ff);
   assign bus_addr  = bus_addr_type'(addr_ff);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the item payload
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff       <= req_action;
         addr_ff      <= req_bus_address;
         wdata_ff     <= req_write_data;
         levels_ff[0] <= req_square_one_level;
         levels_ff[1] <= req_square_two_level;
         levels_ff[2] <= req_wave_level;
         levels_ff[3] <= req_noise_level;
         active_ff    <= req_channel_active;
      end
   end

   // Frame sequencer advances on each tick that reaches the result register
   afsm_frame_seq #(
      .PRESCALE_BITS (PRESCALE_BITS)
   ) u_frame_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (take && (action == ACT_TICK)),
      .strobe  (seq_strobe)
   );

   afsm_mixer u_mix_left (
      .levels       (levels_ff),
      .routing      (left_route_ff),
      .volume       (left_vol_ff),
      .master_on    (master_ff),
      .global_shift (gshift_ff),
      .sample       (left_mix)
   );

   afsm_mixer u_mix_right (
      .levels       (levels_ff),
      .routing      (right_route_ff),
      .volume       (right_vol_ff),
      .master_on    (master_ff),
      .global_shift (gshift_ff),
      .sample       (right_mix)
   );

   // Decode bus reads, tick strobes and run strobes
   always_comb begin
      read_data_in = 8'd0;
      if (action == ACT_READ) begin
         case (bus_addr)
            BUS_VOLUME:  read_data_in = {1'b0, left_vol_ff, 1'b0, right_vol_ff};
            BUS_ROUTING: read_data_in = {left_route_ff, right_route_ff};
            BUS_MASTER:  read_data_in = {master_ff, 3'b000, active_ff};
            default:     read_data_in = 8'd0;
         endcase
      end
      strobe_in = '0;
      run_in    = 4'd0;
      if (action == ACT_TICK) begin
         strobe_in = seq_strobe;
         run_in    = active_ff;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (take) begin
         read_data_ff <= read_data_in;
         strobe_ff    <= strobe_in;
         run_ff       <= run_in;
         left_ff      <= (action == ACT_SAMPLE) ? left_mix : 10'd0;
         right_ff     <= (action == ACT_SAMPLE) ? right_mix : 10'd0;
      end
   end

   // Apply bus writes as the item passes
   always_ff @(posedge clock) begin
      if (reset) begin
         left_vol_ff    <= 3'd0;
         right_vol_ff   <= 3'd0;
         left_route_ff  <= 4'd0;
         right_route_ff <= 4'd0;
         master_ff      <= 1'b0;
      end else if (take && (action == ACT_WRITE)) begin
         case (bus_addr)
            BUS_VOLUME: begin
               right_vol_ff <= wdata_ff[2:0];
               left_vol_ff  <= wdata_ff[6:4];
            end
            BUS_ROUTING: begin
               right_route_ff <= wdata_ff[3:0];
               left_route_ff  <= wdata_ff[7:4];
            end
            BUS_MASTER: begin
               master_ff <= wdata_ff[7];
            end
            default: begin
               master_ff <= master_ff;
            end
         endcase
      end
   end

   // Configuration port: one register, global volume shift
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gshift_ff <= 2'd0;
      end else if (psel && penable && pwrite && pready && (paddr[2] == CSR_GLOBAL_SHIFT)) begin
         gshift_ff <= pwdata[1:0];
      end
   end

   assign prdata = (paddr[2] == CSR_GLOBAL_SHIFT) ? {30'd0, gshift_ff} : 32'd0;

   // Drive result ports
   assign rsp_valid           = out_valid_ff;
   assign rsp_read_data       = read_data_ff;
   assign rsp_length_strobe   = strobe_ff.length;
   assign rsp_sweep_strobe    = strobe_ff.sweep;
   assign rsp_envelope_strobe = strobe_ff.envelope;
   assign rsp_run_strobes     = run_ff;
   assign rsp_left_sample     = left_ff;
   assign rsp_right_sample    = right_ff;

   `AFSM_ASSERT(a_sample_needs_master, clock, reset, (rsp_valid && (rsp_left_sample != 10'd0)) |-> master_ff)
   `AFSM_ASSERT_ALWAYS(a_stall_means_full, clock, req_stall |-> (in_valid_ff && out_valid_ff))
   `AFSM_ASSERT(a_result_held, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid)

endmodule
